[hdl/entity_text_reformatter_top_defines.svh]
// ----------------------------------------------------------------------------
// Entity text reformatter: assertion macros
// Shared assertion forms, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ENTITY_TEXT_REFORMATTER_TOP_DEFINES_SVH
`define ENTITY_TEXT_REFORMATTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETR_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ETR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hdl/etr_pkg.sv]
// ----------------------------------------------------------------------------
// Entity text reformatter: package
// Shared types, character constants, status codes and register indexes.
// ----------------------------------------------------------------------------
package etr_pkg;

    localparam int MAX_INDENT = 4;
    localparam int INDENT_CAP = (MAX_INDENT < 4) ? MAX_INDENT : 4;
    localparam int RUN_MAX    = 5;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_OPEN  = 8'd123;
    localparam logic [7:0] CH_CLOSE = 8'd125;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_OPEN     = 3'd1;
    localparam logic [2:0] ERR_QUOTE    = 3'd2;
    localparam logic [2:0] ERR_CLOSE    = 3'd3;
    localparam logic [2:0] ERR_NO_DATA  = 3'd4;

    localparam logic [1:0] REG_INDENT     = 2'd0;
    localparam logic [1:0] REG_CRLF       = 2'd1;
    localparam logic [1:0] REG_TERMINATOR = 2'd2;

    localparam logic [2:0] RST_INDENT     = 3'd2;
    localparam logic       RST_CRLF       = 1'b1;
    localparam logic       RST_TERMINATOR = 1'b0;

    typedef struct packed {
        logic [2:0] indent;
        logic       crlf;
        logic       term;
    } t_cfg;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    status;
        logic [2:0]              err;
        logic [15:0]             line;
    } t_run;

endpackage

[hdl/etr_parse.sv]
// ----------------------------------------------------------------------------
// Entity text reformatter: parser
// Holds the parse state and turns one accepted byte into a run of results.
// ----------------------------------------------------------------------------
module etr_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_end,
    input  etr_pkg::t_cfg i_cfg,
    output etr_pkg::t_run o_run
);
    import etr_pkg::*;

    typedef enum logic [2:0] {
        PH_OPEN, PH_KEY_Q, PH_KEY, PH_VAL_Q, PH_VAL, PH_CLOSE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_line, n_line;
    logic        r_seen, n_seen;
    logic        r_done, n_done;
    t_run        v_run;
    logic        w_ended;
    logic        w_space;
    logic [2:0]  w_indent;

    function automatic t_run f_put(input t_run r, input logic [7:0] b);
        t_run o;
        o = r;
        o.bytes[o.count] = b;
        o.count = o.count + 3'd1;
        return o;
    endfunction

    function automatic t_run f_status(input t_run r, input logic [2:0] e,
                                      input logic [15:0] l);
        t_run o;
        o = f_put(r, CH_NUL);
        o.status = 1'b1;
        o.err = e;
        o.line = l;
        return o;
    endfunction

    function automatic t_run f_newline(input t_run r, input logic crlf);
        t_run o;
        o = r;
        if (crlf) begin
            o = f_put(o, CH_CR);
        end
        o = f_put(o, CH_LF);
        return o;
    endfunction

    function automatic t_run f_key(input t_run r, input logic [2:0] n);
        t_run o;
        o = r;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < n) begin
                o = f_put(o, CH_SPACE);
            end
        end
        o = f_put(o, CH_QUOTE);
        return o;
    endfunction

    assign w_ended  = i_in_end || (i_in_byte == CH_NUL);
    assign w_space  = (i_in_byte == CH_SPACE) || (i_in_byte >= CH_TAB && i_in_byte <= CH_CR);
    assign w_indent = (i_cfg.indent > 3'(INDENT_CAP)) ? 3'(INDENT_CAP) : i_cfg.indent;

    always_comb begin
        v_run   = '0;
        n_phase = r_phase;
        n_line  = r_line;
        n_seen  = r_seen;
        n_done  = r_done;
        if (!r_done) begin
            if (w_ended) begin
                n_done  = 1'b1;
                n_phase = PH_OPEN;
                unique case (r_phase)
                    PH_OPEN: begin
                        if (!r_seen && !i_cfg.term) begin
                            v_run = f_status(v_run, ERR_NO_DATA, r_line);
                        end else begin
                            if (i_cfg.term) begin
                                v_run = f_put(v_run, CH_NUL);
                            end
                            v_run = f_status(v_run, ERR_OK, r_line);
                        end
                    end
                    PH_CLOSE: v_run = f_status(v_run, ERR_CLOSE, r_line);
                    default:  v_run = f_status(v_run, ERR_QUOTE, r_line);
                endcase
            end else begin
                if (i_in_byte == CH_LF && r_line != 16'hFFFF) begin
                    n_line = r_line + 16'd1;
                end
                unique case (r_phase)
                    PH_OPEN: begin
                        if (!w_space) begin
                            if (i_in_byte == CH_OPEN) begin
                                v_run   = f_put(v_run, CH_OPEN);
                                v_run   = f_newline(v_run, i_cfg.crlf);
                                n_seen  = 1'b1;
                                n_phase = PH_KEY_Q;
                            end else begin
                                v_run  = f_status(v_run, ERR_OPEN, n_line);
                                n_done = 1'b1;
                            end
                        end
                    end
                    PH_KEY_Q: begin
                        if (!w_space) begin
                            if (i_in_byte == CH_QUOTE) begin
                                v_run   = f_key(v_run, w_indent);
                                n_phase = PH_KEY;
                            end else begin
                                v_run  = f_status(v_run, ERR_QUOTE, n_line);
                                n_done = 1'b1;
                            end
                        end
                    end
                    PH_KEY: begin
                        if (i_in_byte == CH_QUOTE) begin
                            v_run   = f_put(v_run, CH_QUOTE);
                            v_run   = f_put(v_run, CH_SPACE);
                            n_phase = PH_VAL_Q;
                        end else begin
                            v_run = f_put(v_run, i_in_byte);
                        end
                    end
                    PH_VAL_Q: begin
                        if (!w_space) begin
                            if (i_in_byte == CH_QUOTE) begin
                                v_run   = f_put(v_run, CH_QUOTE);
                                n_phase = PH_VAL;
                            end else begin
                                v_run  = f_status(v_run, ERR_QUOTE, n_line);
                                n_done = 1'b1;
                            end
                        end
                    end
                    PH_VAL: begin
                        if (i_in_byte == CH_QUOTE) begin
                            v_run   = f_put(v_run, CH_QUOTE);
                            v_run   = f_newline(v_run, i_cfg.crlf);
                            n_phase = PH_CLOSE;
                        end else begin
                            v_run = f_put(v_run, i_in_byte);
                        end
                    end
                    PH_CLOSE: begin
                        if (!w_space) begin
                            if (i_in_byte == CH_QUOTE) begin
                                v_run   = f_key(v_run, w_indent);
                                n_phase = PH_KEY;
                            end else if (i_in_byte == CH_CLOSE) begin
                                v_run   = f_put(v_run, CH_CLOSE);
                                v_run   = f_newline(v_run, i_cfg.crlf);
                                n_phase = PH_OPEN;
                            end else begin
                                v_run  = f_status(v_run, ERR_CLOSE, n_line);
                                n_done = 1'b1;
                            end
                        end
                    end
                    default: n_phase = PH_OPEN;
                endcase
            end
        end
    end

    assign o_run = v_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPEN;
            r_line  <= '0;
            r_seen  <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_seen  <= n_seen;
            r_done  <= n_done;
        end
    end

endmodule

[hdl/etr_drain.sv]
// ----------------------------------------------------------------------------
// Entity text reformatter: result register
// Holds one run of results and hands out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module etr_drain (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_accept,
    input  etr_pkg::t_run i_run,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_out_is_status,
    output logic [2:0]    o_out_error,
    output logic [15:0]   o_out_line,
    output logic          o_out_last
);
    import etr_pkg::*;
    `include "entity_text_reformatter_top_defines.svh"

    logic [RUN_MAX-1:0][7:0] r_bytes;
    logic [2:0]              r_cnt;
    logic                    r_status;
    logic [2:0]              r_err;
    logic [15:0]             r_line;
    logic                    w_take;
    logic                    w_final;

    assign o_out_valid     = (r_cnt != 3'd0);
    assign w_take          = o_out_valid && !i_out_stall;
    assign o_in_stall      = (r_cnt > 3'd1) || ((r_cnt == 3'd1) && i_out_stall);
    assign o_accept        = i_in_valid && !o_in_stall;
    assign w_final         = (r_cnt == 3'd1);
    assign o_out_byte      = r_bytes[0];
    assign o_out_is_status = r_status && w_final;
    assign o_out_error     = o_out_is_status ? r_err : ERR_OK;
    assign o_out_line      = o_out_is_status ? r_line : 16'd0;
    assign o_out_last      = w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_accept) begin
            r_cnt <= i_run.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_bytes  <= i_run.bytes;
            r_status <= i_run.status;
            r_err    <= i_run.err;
            r_line   <= i_run.line;
        end else if (w_take) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    `ETR_ASSERT_SAME(a_multi_stalls, r_cnt > 3'd1, o_in_stall)
    `ETR_ASSERT_SAME(a_status_last, o_out_valid && o_out_is_status, o_out_last)
    `ETR_ASSERT_NEXT(a_drain_step, w_take && !o_accept, r_cnt == $past(r_cnt) - 3'd1)
    `ETR_ASSERT_SAME(a_run_bound, 1'b1, r_cnt <= 3'(RUN_MAX))

endmodule

[hdl/entity_text_reformatter_top.sv]
// ----------------------------------------------------------------------------
// Entity text reformatter: top level
// Reformats entity text into canonical form, one input byte per transfer.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------
//   input   | in        | i_in_valid, o_in_stall | i_in_byte, i_in_end
//   output  | out       | o_out_valid, i_out_stall | byte, status, error, line, last
//   config  | in        | APB psel/penable       | three registers at 0, 4, 8
//
// An input byte is parsed in the cycle it is accepted; its results appear in
// the result register on the next cycle and leave one per cycle unless stalled.
// A byte causes at most five results.
// Input is stalled while more than one result of the previous byte remains,
// or while its last result is held by an output stall.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module entity_text_reformatter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_is_status,
    output logic [2:0]  o_out_error,
    output logic [15:0] o_out_line,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import etr_pkg::*;

    t_cfg r_cfg;
    t_run w_run;
    logic w_accept;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.indent <= RST_INDENT;
            r_cfg.crlf   <= RST_CRLF;
            r_cfg.term   <= RST_TERMINATOR;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_INDENT:     r_cfg.indent <= pwdata[2:0];
                REG_CRLF:       r_cfg.crlf   <= pwdata[0];
                REG_TERMINATOR: r_cfg.term   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_INDENT:     prdata = {29'd0, r_cfg.indent};
            REG_CRLF:       prdata = {31'd0, r_cfg.crlf};
            REG_TERMINATOR: prdata = {31'd0, r_cfg.term};
            default:        prdata = '0;
        endcase
    end

    etr_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_in_byte (i_in_byte),
        .i_in_end  (i_in_end),
        .i_cfg     (r_cfg),
        .o_run     (w_run)
    );

    etr_drain u_drain (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .o_accept        (w_accept),
        .i_run           (w_run),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_out_is_status (o_out_is_status),
        .o_out_error     (o_out_error),
        .o_out_line      (o_out_line),
        .o_out_last      (o_out_last)
    );

endmodule
